/* sv/sorted_priority_queue_macros.svh */
// Assertion macros for the sorted priority queue.
// Included by the top level; needs nothing else.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sorted_priority_queue: check failed");
// When the antecedent holds, the consequent must hold in the same cycle.
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: check failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: check failed");
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop)
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned PrioW    = 8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_VIEW   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_REMOVE = 2'd3
  } spq_mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_e;

  // Source of the id and priority in a result
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_HEAD  = 2'd1,
    SEL_FOUND = 2'd2
  } spq_sel_e;

  typedef struct packed {
    spq_mode_e        mode;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    spq_status_e      status;
    logic [IdW-1:0]   out_id;
    logic [PrioW-1:0] out_priority;
    logic             last;
  } spq_res_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        insert;
    logic        rotate;
    logic        drop;
    logic        grab;
    logic        step;
    logic        load;
    spq_sel_e    sel;
    spq_status_e status;
    logic        last;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    spq_mode_e mode;
    logic      empty;
    logic      full;
    logic      head_match;
    logic      left_last;
    logic      found;
  } spq_stat_t;

endpackage

/* sv/spq_datapath.sv */
// Datapath of the sorted priority queue: the sorted cell chain, occupancy,
// request and result registers. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_req_t   req_i,
  input  spq_pkg::spq_cmd_t   cmd_i,
  output spq_pkg::spq_stat_t  stat_o,
  output spq_pkg::spq_res_t   res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [spq_pkg::IdW-1:0]   id_q   [CAPACITY];
  logic [spq_pkg::IdW-1:0]   id_d   [CAPACITY];
  logic [spq_pkg::PrioW-1:0] prio_q [CAPACITY];
  logic [spq_pkg::PrioW-1:0] prio_d [CAPACITY];
  logic [CAPACITY-1:0]       ge_vec;

  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           left_q, left_d;
  logic                      found_q, found_d;
  logic [spq_pkg::IdW-1:0]   found_id_q;
  logic [spq_pkg::PrioW-1:0] found_prio_q;
  spq_pkg::spq_req_t         req_q;
  spq_pkg::spq_res_t         res_q, res_d;

  // Each cell looks only at its neighbors, at the head and at the request register
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      valid, is_tail, prev_ge;
    logic [spq_pkg::IdW-1:0]   prev_id, next_id;
    logic [spq_pkg::PrioW-1:0] prev_prio, next_prio;

    assign valid     = count_q > CntW'(i);
    assign is_tail   = count_q == CntW'(i + 1);
    assign ge_vec[i] = valid && (prio_q[i] >= req_q.priority_req);

    if (i == 0) begin : g_first
      assign prev_ge   = 1'b1;
      assign prev_id   = id_q[i];
      assign prev_prio = prio_q[i];
    end else begin : g_rest
      assign prev_ge   = ge_vec[i-1];
      assign prev_id   = id_q[i-1];
      assign prev_prio = prio_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_id   = id_q[i];
      assign next_prio = prio_q[i];
    end else begin : g_inner
      assign next_id   = id_q[i+1];
      assign next_prio = prio_q[i+1];
    end

    always_comb begin
      id_d[i]   = id_q[i];
      prio_d[i] = prio_q[i];
      if (cmd_i.insert) begin
        // Entries at or above the new priority stay; the first lower one
        // takes the new entry, the rest move down by one.
        if (!ge_vec[i]) begin
          id_d[i]   = prev_ge ? req_q.task_id : prev_id;
          prio_d[i] = prev_ge ? req_q.priority_req : prev_prio;
        end
      end else if (cmd_i.rotate) begin
        id_d[i]   = is_tail ? id_q[0] : next_id;
        prio_d[i] = is_tail ? prio_q[0] : next_prio;
      end else if (cmd_i.drop) begin
        id_d[i]   = next_id;
        prio_d[i] = next_prio;
      end
    end

    always_ff @(posedge clk_i) begin
      id_q[i]   <= id_d[i];
      prio_q[i] <= prio_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.drop) begin
      count_d = count_q - CntW'(1);
    end

    left_d = left_q;
    if (cmd_i.capture) begin
      left_d = count_q;
    end else if (cmd_i.step) begin
      left_d = left_q - CntW'(1);
    end

    found_d = found_q;
    if (cmd_i.capture) begin
      found_d = 1'b0;
    end else if (cmd_i.grab) begin
      found_d = 1'b1;
    end
  end

  always_comb begin
    res_d        = res_q;
    if (cmd_i.load) begin
      res_d.status = cmd_i.status;
      res_d.last   = cmd_i.last;
      case (cmd_i.sel)
        spq_pkg::SEL_HEAD: begin
          res_d.out_id       = id_q[0];
          res_d.out_priority = prio_q[0];
        end
        spq_pkg::SEL_FOUND: begin
          res_d.out_id       = found_id_q;
          res_d.out_priority = found_prio_q;
        end
        default: begin
          res_d.out_id       = '0;
          res_d.out_priority = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      found_q <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.grab) begin
      found_id_q   <= id_q[0];
      found_prio_q <= prio_q[0];
    end
    res_q <= res_d;
  end

  assign stat_o.mode       = req_q.mode;
  assign stat_o.empty      = count_q == '0;
  assign stat_o.full       = count_q == CntW'(CAPACITY);
  assign stat_o.head_match = id_q[0] == req_q.task_id;
  assign stat_o.left_last  = left_q == CntW'(1);
  assign stat_o.found      = found_q;
  assign res_o             = res_q;

endmodule

/* sv/spq_ctrl.sv */
// Controller of the sorted priority queue: request sequencing and the
// output valid flag. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_VIEW   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.sel    = spq_pkg::SEL_ZERO;
    cmd_o.status = spq_pkg::ST_OK;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
          if (stat_i.mode == spq_pkg::MODE_INSERT) begin
            if (stat_i.full) begin
              cmd_o.status = spq_pkg::ST_FULL;
            end else begin
              cmd_o.insert = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.status = spq_pkg::ST_EMPTY;
          end else if (stat_i.mode == spq_pkg::MODE_POP) begin
            cmd_o.sel  = spq_pkg::SEL_HEAD;
            cmd_o.drop = 1'b1;
          end else begin
            // View and remove walk the chain first
            cmd_o.load = 1'b0;
            cmd_o.last = 1'b0;
            state_d    = (stat_i.mode == spq_pkg::MODE_VIEW) ? S_VIEW : S_SCAN;
          end
        end
      end
      S_VIEW: begin
        // Emit the head, then rotate it to the tail
        if (out_free) begin
          cmd_o.load   = 1'b1;
          cmd_o.sel    = spq_pkg::SEL_HEAD;
          cmd_o.last   = stat_i.left_last;
          cmd_o.rotate = 1'b1;
          cmd_o.step   = 1'b1;
          if (stat_i.left_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        // Drop the first matching head; rotate every other one
        cmd_o.step = 1'b1;
        if (stat_i.head_match && !stat_i.found) begin
          cmd_o.drop = 1'b1;
          cmd_o.grab = 1'b1;
        end else begin
          cmd_o.rotate = 1'b1;
        end
        if (stat_i.left_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
          if (stat_i.found) begin
            cmd_o.sel = spq_pkg::SEL_FOUND;
          end else begin
            cmd_o.status = spq_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* sv/sorted_priority_queue.sv */
// Sorted priority queue of (task id, priority) entries, highest priority at
// the head, equal priorities first in, first out. One request is worked on
// at a time; each result sits in an output register until taken. Insert
// (accepted or refused as full), pop, and a view, pop or remove on an empty
// queue load their result in the execute state that follows accept. View
// streams one entry per cycle, head first, while the output register is
// free or being taken. Remove by id loads its result after a scan: the cell
// chain rotates once through all entries, comparing the id at the head each
// cycle. A load waits while the output register is still full and not taken.
// The next request is accepted the cycle after the final result is loaded.
// Depends on spq_pkg, spq_ctrl, spq_datapath and the macros header.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_res_t out_res_o
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (out_res_o)
  );

  `SPQ_ASSERT_NEXT(a_one_request, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SPQ_ASSERT(a_no_insert_full, clk_i, rst_ni, !(cmd.insert && stat.full))
  `SPQ_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.load, !out_valid_o || out_ready_i)

endmodule

/* tb/sv/spq_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted priority queue. It keeps its own copy of the queue,
// works out the results of every accepted request and compares them in order.
// Depends on spq_pkg.
module spq_result_checker
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  spq_req_t in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  spq_res_t out_res_i,
  output int       fail_count_o,
  output int       pending_o
);

  logic [IdW-1:0]   entry_id   [CAPACITY];
  logic [PrioW-1:0] entry_prio [CAPACITY];
  int unsigned      entry_count;
  spq_res_t         expected_results [$];

  function automatic spq_res_t pack_result(spq_status_e st, logic [IdW-1:0] id,
                                           logic [PrioW-1:0] prio, logic lst);
    spq_res_t res;
    res.status       = st;
    res.out_id       = id;
    res.out_priority = prio;
    res.last         = lst;
    return res;
  endfunction

  // Report the entry at pos, then close the gap behind it.
  task automatic take_entry(int unsigned pos);
    expected_results.push_back(pack_result(ST_OK, entry_id[pos], entry_prio[pos], 1'b1));
    for (int unsigned i = pos; i + 1 < entry_count; i++) begin
      entry_id[i]   = entry_id[i + 1];
      entry_prio[i] = entry_prio[i + 1];
    end
    entry_count--;
  endtask

  task automatic apply_request(spq_req_t req);
    int unsigned pos;
    bit          hit;
    if (req.mode == MODE_INSERT) begin
      if (entry_count >= CAPACITY) begin
        expected_results.push_back(pack_result(ST_FULL, '0, '0, 1'b1));
      end else begin
        // New entry goes behind every entry of equal or higher priority.
        pos = 0;
        while (pos < entry_count && entry_prio[pos] >= req.priority_req) pos++;
        for (int unsigned i = entry_count; i > pos; i--) begin
          entry_id[i]   = entry_id[i - 1];
          entry_prio[i] = entry_prio[i - 1];
        end
        entry_id[pos]   = req.task_id;
        entry_prio[pos] = req.priority_req;
        entry_count++;
        expected_results.push_back(pack_result(ST_OK, '0, '0, 1'b1));
      end
    end else if (entry_count == 0) begin
      expected_results.push_back(pack_result(ST_EMPTY, '0, '0, 1'b1));
    end else begin
      case (req.mode)
        MODE_VIEW: begin
          for (int unsigned i = 0; i < entry_count; i++)
            expected_results.push_back(pack_result(ST_OK, entry_id[i], entry_prio[i],
                                                   i + 1 == entry_count));
        end
        MODE_POP: begin
          take_entry(0);
        end
        default: begin
          hit = 1'b0;
          for (pos = 0; pos < entry_count && !hit; pos++) begin
            if (entry_id[pos] == req.task_id) begin
              hit = 1'b1;
              take_entry(pos);
            end
          end
          if (!hit) expected_results.push_back(pack_result(ST_NOT_FOUND, '0, '0, 1'b1));
        end
      endcase
    end
  endtask

  task automatic check_result(spq_res_t got);
    spq_res_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: status %0d out_id %0h out_priority %0h last %0b",
             got.status, got.out_id, got.out_priority, got.last);
      fail_count_o++;
    end else begin
      want = expected_results.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count_o++;
      end
      if (got.out_id != want.out_id) begin
        $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
        fail_count_o++;
      end
      if (got.out_priority != want.out_priority) begin
        $error("out_priority: expected %0h, got %0h", want.out_priority, got.out_priority);
        fail_count_o++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      entry_count  = 0;
      fail_count_o = 0;
      expected_results.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_res_i);
      if (in_valid_i && in_ready_i) apply_request(in_req_i);
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the sorted priority queue testbench: clock, reset, request stimulus
// and result back-pressure. Depends on spq_pkg, the block and spq_result_checker.
module tb;
  import spq_pkg::*;

  localparam int unsigned RandomItems = 413;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned IdPool      = 16;

  typedef enum int unsigned {
    PH_FILL_ONLY,
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic        clk;
  logic        rst_n;
  logic        req_valid;
  logic        req_ready;
  spq_req_t    req;
  logic        res_valid;
  logic        res_ready;
  spq_res_t    res;
  int          fail_count;
  int          pending_results;
  int unsigned cycle_count;
  int unsigned burst_left;
  logic        rx_hold_req;

  sorted_priority_queue dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_res_o   (res)
  );

  spq_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_req_i     (req),
    .out_valid_i  (res_valid),
    .out_ready_i  (res_ready),
    .out_res_i    (res),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic spq_req_t req_of(spq_mode_e mode, logic [IdW-1:0] id,
                                      logic [PrioW-1:0] prio);
    spq_req_t r;
    r.mode         = mode;
    r.task_id      = id;
    r.priority_req = prio;
    return r;
  endfunction

  // Mostly a small pool of ids so removes find their target.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return IdW'($urandom);
    return IdW'($urandom_range(0, IdPool - 1));
  endfunction

  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return PrioW'($urandom);
    endcase
  endfunction

  function automatic spq_req_t random_request(phase_e ph);
    int unsigned roll, ins_pct, view_pct, pop_pct;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL_ONLY: begin ins_pct = 100; view_pct = 0;  pop_pct = 0;  end
      PH_FILL:      begin ins_pct = 70;  view_pct = 10; pop_pct = 10; end
      PH_DRAIN:     begin ins_pct = 15;  view_pct = 10; pop_pct = 45; end
      default:      begin ins_pct = 40;  view_pct = 15; pop_pct = 20; end
    endcase
    if (roll < ins_pct) return req_of(MODE_INSERT, pick_id(), pick_prio());
    if (roll < ins_pct + view_pct)
      return req_of(MODE_VIEW, IdW'($urandom), PrioW'($urandom));
    if (roll < ins_pct + view_pct + pop_pct)
      return req_of(MODE_POP, IdW'($urandom), PrioW'($urandom));
    return req_of(MODE_REMOVE, pick_id(), PrioW'($urandom));
  endfunction

  // Offer one request inside a burst; between bursts drop valid for a while.
  task automatic send_request(spq_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Receiver: stall rate changes segment by segment, plus one long hold-off.
  initial begin : result_taker
    int unsigned seg_left, stall_pct, hold_left;
    bit          hold_used;
    res_ready = 1'b0;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LongHold;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_ready = 1'b0;
      end else begin
        res_ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_priority_queue verification failed");
    $finish;
  end

  initial begin : stimulus
    phase_e      ph;
    int unsigned sent, phase_len, phase_idx;
    rst_n       = 1'b0;
    req_valid   = 1'b0;
    req         = '0;
    rx_hold_req = 1'b0;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty queue on every non-insert mode.
    send_request(req_of(MODE_VIEW, 16'h0000, 8'h00));
    send_request(req_of(MODE_POP, 16'hFFFF, 8'hFF));
    send_request(req_of(MODE_REMOVE, 16'hFFFF, 8'h00));
    // Priority extremes and ties served first in, first out.
    send_request(req_of(MODE_INSERT, 16'h0000, 8'h00));
    send_request(req_of(MODE_INSERT, 16'hFFFF, 8'hFF));
    send_request(req_of(MODE_INSERT, 16'h00A5, 8'hFF));
    send_request(req_of(MODE_INSERT, 16'h5A00, 8'h00));
    send_request(req_of(MODE_INSERT, 16'h0100, 8'h80));
    send_request(req_of(MODE_VIEW, 16'h0000, 8'h00));
    // Remove at tail, in the middle, a missing id, then at head.
    send_request(req_of(MODE_REMOVE, 16'h5A00, 8'h00));
    send_request(req_of(MODE_REMOVE, 16'h0100, 8'h00));
    send_request(req_of(MODE_REMOVE, 16'h1234, 8'h00));
    send_request(req_of(MODE_REMOVE, 16'hFFFF, 8'h00));
    send_request(req_of(MODE_POP, 16'h0000, 8'h00));
    send_request(req_of(MODE_VIEW, 16'h0000, 8'h00));
    send_request(req_of(MODE_POP, 16'h0000, 8'h00));
    send_request(req_of(MODE_VIEW, 16'h0000, 8'h00));
    drain_results();

    // Fill past capacity first, then drain, then random phases.
    sent      = 0;
    phase_idx = 0;
    while (sent < RandomItems) begin
      case (phase_idx)
        0:       ph = PH_FILL_ONLY;
        1:       ph = PH_DRAIN;
        default: ph = phase_e'($urandom_range(PH_FILL, PH_MIXED));
      endcase
      phase_len = (phase_idx == 0) ? 20 : $urandom_range(20, 60);
      if (phase_len > RandomItems - sent) phase_len = RandomItems - sent;
      if (phase_idx == 2) begin
        @(posedge clk);
        rx_hold_req = 1'b1;
      end
      repeat (phase_len) begin
        send_request(random_request(ph));
        sent++;
      end
      if (phase_idx == 0 || $urandom_range(0, 1) == 1) drain_results();
      phase_idx++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  end

endmodule
